### src/binary_image_rank_reduce_defines.svh
// Assertion macros used by the checker file of the rank reducer.
`ifndef BINARY_IMAGE_RANK_REDUCE_DEFINES_SVH
`define BINARY_IMAGE_RANK_REDUCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define BIRR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rank reducer check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define BIRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rank reducer check failed");

`endif

### src/birr_pkg.sv
// Shared types, constants and helper functions of the rank reducer.
`default_nettype none
package birr_pkg;

  localparam int MAX_ROW_PIXELS_C = 2048;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [1:0] KIND_HPAIR = 2'd0;
  localparam logic [1:0] KIND_VPAIR = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;

  localparam logic [2:0] RANK_MIN = 3'd1;
  localparam logic [2:0] RANK_PAIR_MAX = 3'd2;
  localparam logic [2:0] RANK_MAX = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KIND,
    REG_RANK,
    REG_WIDTH,
    REG_COUNT,
    REG_MSB
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] rank;
    logic [2:0] prank;
    logic       msb;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       col_odd;
    logic       last_col;
    logic       flast;
    logic       store;
  } s1_t;

  function automatic logic [7:0] bit_order(input logic [7:0] b, input logic msb);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return msb ? r : b;
  endfunction

  function automatic logic [1:0] norm_kind(input logic [1:0] k);
    return (k > KIND_BLOCK) ? KIND_BLOCK : k;
  endfunction

  function automatic logic [2:0] norm_rank(input logic [2:0] r);
    logic [2:0] v;
    v = (r < RANK_MIN) ? RANK_MIN : r;
    return (v > RANK_MAX) ? RANK_MAX : v;
  endfunction

  function automatic logic [2:0] pair_rank(input logic [2:0] r);
    return (r > RANK_PAIR_MAX) ? RANK_PAIR_MAX : r;
  endfunction

endpackage
`default_nettype wire

### src/birr_lane.sv
// One counting lane: tests a group of up to four pixels against the rank.
`default_nettype none
module birr_lane
  import birr_pkg::*;
(
  input  logic [3:0] px,
  input  logic [2:0] rank,
  output logic       hit
);

  logic [2:0] count;

  always_comb begin
    count = 3'({2'b0, px[0]}) + 3'({2'b0, px[1]}) + 3'({2'b0, px[2]}) + 3'({2'b0, px[3]});
    hit = (count >= rank);
  end

endmodule
`default_nettype wire

### src/birr_front.sv
// Input stage: column and row counters, line store and the first pipeline register.
`default_nettype none
module birr_front
  import birr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_C
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic [11:0] row_width,
  input  logic [12:0] row_count,
  output s1_t         s1,
  output logic [7:0]  s1_top,
  output logic        s1_valid
);

  localparam int STORE_DEPTH = (MAX_ROW_PIXELS + 7) / 8;
  localparam int CW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WW = ($clog2(MAX_ROW_PIXELS + 1) > 12) ? $clog2(MAX_ROW_PIXELS + 1) : 12;

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    top_r;
  s1_t           s1_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [11:0]   row_r, row_nxt;

  logic [WW-1:0] w_ext, w_sat, wm1;
  logic [CW-1:0] last_c, col;
  logic [12:0]   nr, even_nr, rp1;
  logic [11:0]   last_r, r;
  logic          acc, last_col, last_row, vertical, store, flast;
  logic [7:0]    pix;

  always_comb begin
    w_ext = WW'(row_width);
    w_sat = (w_ext == '0) ? WW'(1) : w_ext;
    w_sat = (w_sat > WW'(MAX_ROW_PIXELS)) ? WW'(MAX_ROW_PIXELS) : w_sat;
    wm1 = w_sat - WW'(1);
    last_c = CW'(wm1 >> 3);
    nr = (row_count == 13'd0) ? 13'd1 : row_count;
    nr = (nr > 13'd4096) ? 13'd4096 : nr;
    last_r = 12'(nr - 13'd1);
    even_nr = {nr[12:1], 1'b0};
    col = (col_r > last_c) ? last_c : col_r;
    r = (row_r > last_r) ? last_r : row_r;
    rp1 = {1'b0, r} + 13'd1;
    last_col = (col == last_c);
    last_row = (r == last_r);
    vertical = (cfg.kind != KIND_HPAIR);
    store = vertical && !r[0];
    flast = vertical ? (rp1 >= even_nr) : last_row;
    pix = bit_order(in_byte, cfg.msb);
    acc = in_valid && adv;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? 12'd0 : 12'(rp1);
      end else begin
        col_nxt = col + CW'(1);
        row_nxt = row_r;
      end
    end
    s1_valid_nxt = adv ? in_valid : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.pix <= pix;
      s1_r.col_odd <= col[0];
      s1_r.last_col <= last_col;
      s1_r.flast <= flast;
      s1_r.store <= store;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (store) begin
        mem[col] <= pix;
      end else begin
        top_r <= mem[col];
      end
    end
  end

  assign s1 = s1_r;
  assign s1_top = top_r;
  assign s1_valid = s1_valid_r;

endmodule
`default_nettype wire

### src/birr_merge.sv
// Counting lanes, half-byte merge and the output register.
`default_nettype none
module birr_merge
  import birr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  s1_t        s1,
  input  logic [7:0] s1_top,
  input  logic       s1_valid,
  input  logic       out_stall,
  output logic       adv,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_row_last,
  output logic       out_frame_last
);

  logic [7:0] hits;
  logic [3:0] nib;
  logic [7:0] res;
  logic       emit, out_free, move, pair_kind;
  logic [3:0] held_half_r, held_half_nxt;
  logic       half_pending_r, half_pending_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_row_last_r, out_frame_last_r;

  assign pair_kind = (cfg.kind != KIND_VPAIR);

  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic [3:0] px;
    logic [2:0] rank;
    if (k < 4) begin : g_dual
      always_comb begin
        if (!pair_kind) begin
          px = {2'b00, s1_top[k], s1.pix[k]};
          rank = cfg.prank;
        end else if (cfg.kind == KIND_BLOCK) begin
          px = {s1_top[2*k+1], s1_top[2*k], s1.pix[2*k+1], s1.pix[2*k]};
          rank = cfg.rank;
        end else begin
          px = {2'b00, s1.pix[2*k+1], s1.pix[2*k]};
          rank = cfg.prank;
        end
      end
    end else begin : g_vert
      always_comb begin
        px = {2'b00, s1_top[k], s1.pix[k]};
        rank = cfg.prank;
      end
    end
    birr_lane u_lane (
      .px  (px),
      .rank(rank),
      .hit (hits[k])
    );
  end

  always_comb begin
    nib = hits[3:0];
    if (!pair_kind) begin
      res = hits;
    end else if (!s1.col_odd) begin
      res = {4'h0, nib};
    end else begin
      res = {nib, half_pending_r ? held_half_r : 4'h0};
    end
    emit = s1_valid && !s1.store && (!pair_kind || s1.col_odd || s1.last_col);
    out_free = !out_valid_r || !out_stall;
    adv = !s1_valid || !emit || out_free;
    move = s1_valid && adv;
  end

  always_comb begin
    held_half_nxt = held_half_r;
    half_pending_nxt = half_pending_r;
    if (move) begin
      if (s1.store) begin
        half_pending_nxt = 1'b0;
      end else if (pair_kind) begin
        if (!s1.col_odd && !s1.last_col) begin
          held_half_nxt = nib;
          half_pending_nxt = 1'b1;
        end else begin
          half_pending_nxt = 1'b0;
        end
      end
    end
    out_valid_nxt = out_free ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_half_r <= 4'h0;
      half_pending_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_half_r <= held_half_nxt;
      half_pending_r <= half_pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_byte_r <= bit_order(res, cfg.msb);
      out_row_last_r <= s1.last_col;
      out_frame_last_r <= s1.last_col && s1.flast;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_row_last = out_row_last_r;
  assign out_frame_last = out_frame_last_r;

endmodule
`default_nettype wire

### src/binary_image_rank_reduce.sv
// Top level of the packed binary image 2:1 rank reducer.
// Input words carry eight pixels of one source row in raster order; each
// row is padded to whole bytes. An input word is taken on a rising edge with
// in_valid high and in_stall low. Output words leave the same way on the
// out_ channel, with out_row_last and out_frame_last marking row and image
// ends. Registers are written on the cfg_ channel (cfg_ready is always high)
// and must only change while the block is empty.
// An input word produces zero or one output word. A produced word passes the
// first pipeline register and the output register. One input word is taken
// per cycle while out_stall is low; the single-port line store is written
// (even rows of the vertical kinds) or read once per word, setting that rate.
// When the receiver stalls, the output register holds and the stage behind
// it fills; in_stall rises only once a waiting word would need the output.
// Reset clears the counters, the held half byte and all valid flags, and
// loads the register defaults; the line store needs no clearing.
`default_nettype none
module binary_image_rank_reduce
  import birr_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_C
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_row_last,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]  kind_r;
  logic [2:0]  rank_r;
  logic [11:0] width_r;
  logic [12:0] count_r;
  logic        msb_r;
  cfg_t        cfg;
  s1_t         s1;
  logic [7:0]  s1_top;
  logic        s1_valid, adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_BLOCK;
      rank_r <= RANK_MIN;
      width_r <= 12'd2048;
      count_r <= 13'd480;
      msb_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KIND:  kind_r <= cfg_data[1:0];
        REG_RANK:  rank_r <= cfg_data[2:0];
        REG_WIDTH: width_r <= cfg_data[11:0];
        REG_COUNT: count_r <= cfg_data[12:0];
        REG_MSB:   msb_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.kind = norm_kind(kind_r);
    cfg.rank = norm_rank(rank_r);
    cfg.prank = pair_rank(cfg.rank);
    cfg.msb = msb_r;
  end

  assign cfg_ready = 1'b1;
  assign in_stall = !adv;

  birr_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .adv      (adv),
    .cfg      (cfg),
    .row_width(width_r),
    .row_count(count_r),
    .s1       (s1),
    .s1_top   (s1_top),
    .s1_valid (s1_valid)
  );

  birr_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .s1            (s1),
    .s1_top        (s1_top),
    .s1_valid      (s1_valid),
    .out_stall     (out_stall),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_row_last  (out_row_last),
    .out_frame_last(out_frame_last)
  );

endmodule
`default_nettype wire

### src/binary_image_rank_reduce_chk.sv
// Port-level checker of the rank reducer and its bind to the top level.
`default_nettype none
`include "binary_image_rank_reduce_defines.svh"
module binary_image_rank_reduce_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_row_last,
  input logic       out_frame_last
);

  `BIRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))
  `BIRR_ASSERT_NOW(a_frame_in_row, out_valid && out_frame_last, out_row_last)
  `BIRR_ASSERT_NOW(a_out_from_in, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind binary_image_rank_reduce binary_image_rank_reduce_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_row_last  (out_row_last),
  .out_frame_last(out_frame_last)
);
`default_nettype wire
